// File: src/mbrtu_pkg.sv
// Shared types and constants of the Modbus RTU frame receiver.
`default_nettype none
package mbrtu_pkg;

  localparam logic [7:0]  BCAST_ADDR   = 8'hFF;
  localparam logic [7:0]  DEV_ADDR_RST = 8'h01;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  localparam logic [7:0]  FC_READ_COILS = 8'h01;
  localparam logic [7:0]  FC_READ_HREGS = 8'h03;
  localparam logic [7:0]  FC_WRITE_COIL = 8'h05;
  localparam logic [7:0]  FC_WRITE_MULT = 8'h10;

  localparam logic [8:0]  LEN_FIXED     = 9'd4;
  localparam logic [8:0]  LEN_MULT_HEAD = 9'd6;
  localparam logic [8:0]  LEN_MULT_BASE = 9'd5;
  localparam logic [8:0]  POS_COUNT     = 9'd6;

  localparam logic        REG_DEV_ADDR  = 1'b0;

  typedef enum logic [2:0] {
    ST_ABSORB    = 3'd0,
    ST_PAYLOAD   = 3'd1,
    ST_OK        = 3'd2,
    ST_ADDR_MISS = 3'd3,
    ST_BAD_FUNC  = 3'd4,
    ST_CRC_ERR   = 3'd5,
    ST_BC_REJECT = 3'd6
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  func_code;
    logic [8:0]  payload_index;
    logic [7:0]  payload_byte;
    logic        broadcast;
  } result_t;

endpackage
`default_nettype wire

// File: src/mbrtu_crc.sv
// Byte-wide CRC-16/MODBUS update.
`default_nettype none
module mbrtu_crc (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] crc_o
);

  always_comb begin
    logic [15:0] acc;
    acc = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ mbrtu_pkg::CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_o = acc;
  end

endmodule
`default_nettype wire

// File: src/mbrtu_parse.sv
// Frame tracking state and per-beat status decode.
`default_nettype none
module mbrtu_parse (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                beat_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [7:0]          dev_addr_i,
  output mbrtu_pkg::result_t       result_o
);

  logic [8:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [7:0]  func_q, func_d;
  logic [8:0]  len_q, len_d;
  logic        bc_q, bc_d;
  logic [31:0] head_q, head_d;

  logic [15:0] crc_in, crc_upd;
  logic [8:0]  dpos;
  logic [8:0]  len_eff;
  logic        addr_hit;
  logic        func_ok;
  mbrtu_pkg::result_t res;

  assign crc_in   = (pos_q == 9'd0) ? mbrtu_pkg::CRC_INIT : crc_q;
  assign dpos     = pos_q - 9'd2;
  assign addr_hit = (rx_byte_i == dev_addr_i) || (rx_byte_i == mbrtu_pkg::BCAST_ADDR);
  assign func_ok  = (rx_byte_i == mbrtu_pkg::FC_READ_COILS) ||
                    (rx_byte_i == mbrtu_pkg::FC_READ_HREGS) ||
                    (rx_byte_i == mbrtu_pkg::FC_WRITE_COIL) ||
                    (rx_byte_i == mbrtu_pkg::FC_WRITE_MULT);
  assign len_eff  = (pos_q == mbrtu_pkg::POS_COUNT && func_q == mbrtu_pkg::FC_WRITE_MULT) ?
                    ({1'b0, rx_byte_i} + mbrtu_pkg::LEN_MULT_BASE) : len_q;

  mbrtu_crc u_crc (
    .crc_i  (crc_in),
    .byte_i (rx_byte_i),
    .crc_o  (crc_upd)
  );

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    func_d   = func_q;
    len_d    = len_q;
    bc_d     = bc_q;
    head_d   = head_q;
    res.status        = mbrtu_pkg::ST_ABSORB;
    res.func_code     = 8'h00;
    res.payload_index = 9'd0;
    res.payload_byte  = 8'h00;
    res.broadcast     = 1'b0;

    if (pos_q == 9'd0) begin
      if (addr_hit) begin
        bc_d   = (rx_byte_i != dev_addr_i);
        crc_d  = crc_upd;
        func_d = 8'h00;
        head_d = 32'h0;
        pos_d  = 9'd1;
        res.broadcast = (rx_byte_i != dev_addr_i);
      end else begin
        res.status = mbrtu_pkg::ST_ADDR_MISS;
        pos_d = 9'd0;
        crc_d = mbrtu_pkg::CRC_INIT;
        bc_d  = 1'b0;
      end
    end else if (pos_q == 9'd1) begin
      func_d = rx_byte_i;
      res.func_code = rx_byte_i;
      res.broadcast = bc_q;
      if (func_ok) begin
        len_d = (rx_byte_i == mbrtu_pkg::FC_WRITE_MULT) ? mbrtu_pkg::LEN_MULT_HEAD :
                                                          mbrtu_pkg::LEN_FIXED;
        crc_d = crc_upd;
        pos_d = 9'd2;
      end else begin
        res.status = mbrtu_pkg::ST_BAD_FUNC;
        pos_d = 9'd0;
        crc_d = mbrtu_pkg::CRC_INIT;
        bc_d  = 1'b0;
      end
    end else begin
      res.func_code = func_q;
      res.broadcast = bc_q;
      len_d = len_eff;
      if (dpos < len_eff) begin
        crc_d = crc_upd;
        if (dpos < 9'd4) begin
          case (dpos[1:0])
            2'd0:    head_d[31:24] = rx_byte_i;
            2'd1:    head_d[23:16] = rx_byte_i;
            2'd2:    head_d[15:8]  = rx_byte_i;
            default: head_d[7:0]   = rx_byte_i;
          endcase
        end
        res.status        = mbrtu_pkg::ST_PAYLOAD;
        res.payload_index = dpos;
        res.payload_byte  = rx_byte_i;
        pos_d = pos_q + 9'd1;
      end else if (dpos == len_eff) begin
        crc_lo_d = rx_byte_i;
        pos_d    = pos_q + 9'd1;
      end else begin
        if ({rx_byte_i, crc_lo_q} != crc_q) begin
          res.status = mbrtu_pkg::ST_CRC_ERR;
        end else if (bc_q) begin
          res.status = (head_q == 32'h0000_0001) ? mbrtu_pkg::ST_OK :
                                                   mbrtu_pkg::ST_BC_REJECT;
        end else begin
          res.status = mbrtu_pkg::ST_OK;
        end
        pos_d = 9'd0;
        crc_d = mbrtu_pkg::CRC_INIT;
        bc_d  = 1'b0;
      end
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 9'd0;
      crc_q    <= mbrtu_pkg::CRC_INIT;
      crc_lo_q <= 8'h00;
      func_q   <= 8'h00;
      len_q    <= 9'd0;
      bc_q     <= 1'b0;
      head_q   <= 32'h0;
    end else if (beat_i) begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      func_q   <= func_d;
      len_q    <= len_d;
      bc_q     <= bc_d;
      head_q   <= head_d;
    end
  end

  a_miss_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && res.status == mbrtu_pkg::ST_ADDR_MISS |=> pos_q == 9'd0)
    else $error("address miss did not restart frame");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && (res.status == mbrtu_pkg::ST_OK || res.status == mbrtu_pkg::ST_CRC_ERR ||
               res.status == mbrtu_pkg::ST_BC_REJECT)
    |=> pos_q == 9'd0 && crc_q == mbrtu_pkg::CRC_INIT && !bc_q)
    else $error("frame end did not clear state");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && res.status == mbrtu_pkg::ST_PAYLOAD |-> res.payload_index < 9'd260)
    else $error("payload index out of range");

endmodule
`default_nettype wire

// File: src/mbrtu_outq.sv
// Two-entry result queue between the decode and the output channel.
`default_nettype none
module mbrtu_outq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire mbrtu_pkg::result_t  data_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output mbrtu_pkg::result_t       data_o
);

  mbrtu_pkg::result_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue overflow");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != 2'd0)
    else $error("pop from empty result queue");

endmodule
`default_nettype wire

// File: src/modbus_rtu_frame_receiver_unit.sv
// Top level of the Modbus RTU frame receiver with its register port.
// Decode is combinational; a status beat is queued when its byte is accepted.
// Throughput: one byte per cycle unless the queue is full; CRC update is combinational.
// A two-entry result queue keeps input beats flowing while one result waits.
// Reset: frame position 0, CRC 0xFFFF, device address 1, result queue empty.
`default_nettype none
module modbus_rtu_frame_receiver_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       func_code_o,
  output logic [8:0]       payload_index_o,
  output logic [7:0]       payload_byte_o,
  output logic             broadcast_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] dev_addr_q;
  logic       reg_hit;
  logic       beat;
  logic       q_full;
  mbrtu_pkg::result_t res, head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == mbrtu_pkg::REG_DEV_ADDR);
  assign prdata  = reg_hit ? {24'h0, dev_addr_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= mbrtu_pkg::DEV_ADDR_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      dev_addr_q <= pwdata[7:0];
    end
  end

  assign in_ready_o = !q_full;
  assign beat       = in_valid_i && in_ready_o;

  mbrtu_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .rx_byte_i  (rx_byte_i),
    .dev_addr_i (dev_addr_q),
    .result_o   (res)
  );

  mbrtu_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (beat),
    .data_i  (res),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .pop_i   (out_valid_o && out_ready_i),
    .data_o  (head)
  );

  assign status_o        = head.status;
  assign func_code_o     = head.func_code;
  assign payload_index_o = head.payload_index;
  assign payload_byte_o  = head.payload_byte;
  assign broadcast_o     = head.broadcast;

endmodule
`default_nettype wire
